// ===== hdl/trc_pkg.sv =====
package trc_pkg;

	localparam int MaxNodes   = 1024;
	localparam int NodeBits   = 10;
	localparam int CountBits  = 11;
	localparam int WeightBits = 30;
	localparam int EdgeCap    = MaxNodes - 1;
	localparam int EdgeBits   = 10;
	localparam int DepthBits  = 11;

	localparam logic FuncAddEdge = 1'b0;
	localparam logic FuncQuery   = 1'b1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_req;    // capture the input request
		logic add_edge;    // write the captured edge if it qualifies
		logic clr_step;    // clear one visited entry
		logic push_start;  // mark and push the start node
		logic pop;         // pop the next node to expand
		logic scan_rd;     // issue an edge read
		logic scan_eval;   // act on the registered edge read and its visited mark
		logic out_load;    // load the result register
	} trc_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_query;
		logic start_bad;
		logic clr_done;
		logic stack_empty;
		logic scan_last;   // the edge read being issued is the last one
		logic no_edges;
	} trc_sts_t;

endpackage

// ===== hdl/threshold_reach_counter_core.sv =====
// Threshold reach counter. Edge requests (func 0) store one undirected weighted edge. A
// query request (func 1) clears the 1024 visited marks one per cycle, then walks the
// graph depth first: each popped node costs one pass over the stored edges, each edge
// going through the edge read, the read of the candidate's visited mark, then the
// decision, through the single read port of the edge table. The input is stalled for
// the whole of a request; a finished result waits in an output register.
module threshold_reach_counter_core (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [trc_pkg::CountBits-1:0]         cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic                                  func,
	input  logic [trc_pkg::NodeBits-1:0]          end_a,
	input  logic [trc_pkg::NodeBits-1:0]          end_b,
	input  logic [trc_pkg::WeightBits-1:0]        edge_weight,
	input  logic [trc_pkg::NodeBits-1:0]          start_node,
	input  logic [trc_pkg::WeightBits-1:0]        threshold,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [trc_pkg::NodeBits-1:0]          reach_count,
	output logic                                  bad_start
);

	trc_pkg::trc_cmd_t             cmd;
	trc_pkg::trc_sts_t             sts;
	logic [trc_pkg::CountBits-1:0] node_count_q;

	// The node count register is always ready; it is sampled when a request is taken.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= trc_pkg::CountBits'(trc_pkg::MaxNodes);
		end else if (cfg_valid) begin
			node_count_q <= cfg_data;
		end
	end

	trc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	trc_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.node_count  (node_count_q),
		.func        (func),
		.end_a       (end_a),
		.end_b       (end_b),
		.edge_weight (edge_weight),
		.start_node  (start_node),
		.threshold   (threshold),
		.reach_count (reach_count),
		.bad_start   (bad_start)
	);

	// A result is only loaded once per query.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> !cmd.out_load)
		else $error("result loaded twice");

	// Edge writes and walk commands never coincide.
	assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.add_edge && (cmd.scan_rd || cmd.pop || cmd.push_start)))
		else $error("edge write during walk");

	// A bad start always reports a zero count.
	assert property (@(posedge clk) disable iff (!arst_n)
		$past(cmd.out_load) && bad_start |-> reach_count == '0)
		else $error("bad start with nonzero count");

endmodule

// ===== hdl/trc_datapath.sv =====
module trc_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  trc_pkg::trc_cmd_t                   cmd,
	output trc_pkg::trc_sts_t                   sts,
	input  logic [trc_pkg::CountBits-1:0]       node_count,
	input  logic                                func,
	input  logic [trc_pkg::NodeBits-1:0]        end_a,
	input  logic [trc_pkg::NodeBits-1:0]        end_b,
	input  logic [trc_pkg::WeightBits-1:0]      edge_weight,
	input  logic [trc_pkg::NodeBits-1:0]        start_node,
	input  logic [trc_pkg::WeightBits-1:0]      threshold,
	output logic [trc_pkg::NodeBits-1:0]        reach_count,
	output logic                                bad_start
);

	logic [trc_pkg::NodeBits-1:0]   edge_first [trc_pkg::EdgeCap];
	logic [trc_pkg::NodeBits-1:0]   edge_second [trc_pkg::EdgeCap];
	logic [trc_pkg::WeightBits-1:0] edge_cost [trc_pkg::EdgeCap];
	logic                           visited [trc_pkg::MaxNodes];
	logic [trc_pkg::NodeBits-1:0]   stack_mem [trc_pkg::MaxNodes];

	logic                           func_q;
	logic [trc_pkg::NodeBits-1:0]   a_q, b_q, start_q;
	logic [trc_pkg::WeightBits-1:0] w_q, thr_q;
	logic [trc_pkg::CountBits-1:0]  limit_q;
	logic [trc_pkg::EdgeBits-1:0]   edges_held_q;
	logic [trc_pkg::EdgeBits-1:0]   scan_idx_q;
	logic [trc_pkg::NodeBits-1:0]   clr_idx_q;
	logic                           clr_done_q;
	logic [trc_pkg::DepthBits-1:0]  depth_q;
	logic [trc_pkg::NodeBits-1:0]   here_q;
	logic [trc_pkg::NodeBits-1:0]   found_q;
	logic [trc_pkg::NodeBits-1:0]   ea_q, eb_q;
	logic [trc_pkg::WeightBits-1:0] ew_q;
	logic [trc_pkg::NodeBits-1:0]   vis_idx;
	logic                           vis_rd_q;
	logic [trc_pkg::NodeBits-1:0]   next_node;
	logic                           hit;
	logic                           take;
	logic                           edge_ok;

	always_comb begin
		edge_ok = (a_q < limit_q[trc_pkg::NodeBits:0]) && (b_q < limit_q)
			&& (edges_held_q < trc_pkg::EdgeBits'(trc_pkg::EdgeCap));
		hit = 1'b0;
		next_node = eb_q;
		if (ew_q >= thr_q && ea_q < limit_q && eb_q < limit_q) begin
			if (ea_q == here_q) begin
				hit = 1'b1;
				next_node = eb_q;
			end else if (eb_q == here_q) begin
				hit = 1'b1;
				next_node = ea_q;
			end
		end
		take = cmd.scan_eval && hit && !vis_rd_q;
		vis_idx = clr_idx_q;
		if (cmd.push_start) vis_idx = start_q;
		else if (take) vis_idx = next_node;
	end

	// Visited marks: one bit per node. The mark of the candidate is read into a register
	// in the cycle after the edge read, while the edge data is held, and used in the cycle after that.
	always_ff @(posedge clk) begin
		if (cmd.clr_step || cmd.push_start || take) begin
			visited[vis_idx] <= !cmd.clr_step;
		end
		vis_rd_q <= visited[next_node];
	end

	always_ff @(posedge clk) begin
		if (cmd.add_edge && edge_ok) begin
			edge_first[edges_held_q]  <= a_q;
			edge_second[edges_held_q] <= b_q;
			edge_cost[edges_held_q]   <= w_q;
		end
		if (cmd.scan_rd) begin
			ea_q <= edge_first[scan_idx_q];
			eb_q <= edge_second[scan_idx_q];
			ew_q <= edge_cost[scan_idx_q];
		end
	end

	// Stack memory: pop read is registered into here_q.
	always_ff @(posedge clk) begin
		if (cmd.push_start) begin
			stack_mem[trc_pkg::NodeBits'(depth_q)] <= start_q;
		end else if (take && depth_q < trc_pkg::DepthBits'(trc_pkg::MaxNodes)) begin
			stack_mem[trc_pkg::NodeBits'(depth_q)] <= next_node;
		end
		if (cmd.pop) begin
			here_q <= stack_mem[trc_pkg::NodeBits'(depth_q - 1'b1)];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			func_q  <= func;
			a_q     <= end_a;
			b_q     <= end_b;
			w_q     <= edge_weight;
			start_q <= start_node;
			thr_q   <= threshold;
			limit_q <= (node_count > trc_pkg::CountBits'(trc_pkg::MaxNodes))
				? trc_pkg::CountBits'(trc_pkg::MaxNodes) : node_count;
		end
		if (cmd.out_load) begin
			reach_count <= sts.start_bad ? '0 : found_q;
			bad_start   <= sts.start_bad;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edges_held_q <= '0;
			scan_idx_q   <= '0;
			clr_idx_q    <= '0;
			clr_done_q   <= 1'b0;
			depth_q      <= '0;
			found_q      <= '0;
		end else begin
			if (cmd.add_edge && edge_ok) edges_held_q <= edges_held_q + 1'b1;
			if (cmd.load_req) begin
				clr_idx_q  <= '0;
				clr_done_q <= 1'b0;
				found_q    <= '0;
				depth_q    <= '0;
			end
			if (cmd.clr_step) begin
				clr_idx_q <= clr_idx_q + 1'b1;
				if (clr_idx_q == trc_pkg::NodeBits'(trc_pkg::MaxNodes - 1)) clr_done_q <= 1'b1;
			end
			if (cmd.push_start) depth_q <= depth_q + 1'b1;
			if (cmd.pop) begin
				depth_q    <= depth_q - 1'b1;
				scan_idx_q <= '0;
			end
			if (cmd.scan_rd) scan_idx_q <= scan_idx_q + 1'b1;
			if (take) begin
				found_q <= found_q + 1'b1;
				if (depth_q < trc_pkg::DepthBits'(trc_pkg::MaxNodes)) depth_q <= depth_q + 1'b1;
			end
		end
	end

	always_comb begin
		sts.is_query    = (func_q == trc_pkg::FuncQuery);
		sts.start_bad   = !(start_q < limit_q);
		sts.clr_done    = clr_done_q;
		sts.stack_empty = (depth_q == '0);
		sts.scan_last   = (scan_idx_q == edges_held_q - 1'b1);
		sts.no_edges    = (edges_held_q == '0);
	end

endmodule

// ===== hdl/trc_ctrl.sv =====
module trc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	output trc_pkg::trc_cmd_t cmd,
	input  trc_pkg::trc_sts_t sts
);

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b00000001,
		ST_DEC   = 8'b00000010,
		ST_CLR   = 8'b00000100,
		ST_POP   = 8'b00001000,
		ST_SCAN  = 8'b00010000,
		ST_EVAL  = 8'b00100000,
		ST_CHK   = 8'b01000000,
		ST_DONE  = 8'b10000000
	} trc_state_t;

	trc_state_t state_q, state_d;
	logic       out_valid_q;
	logic       out_free;
	logic       eval_last_q;

	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign in_stall  = (state_q != ST_IDLE);

	always_comb begin
		cmd = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load_req = 1'b1;
					state_d = ST_DEC;
				end
			end
			ST_DEC: begin
				if (!sts.is_query) begin
					cmd.add_edge = 1'b1;
					state_d = ST_IDLE;
				end else if (sts.start_bad) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_CLR;
				end
			end
			ST_CLR: begin
				if (sts.clr_done) begin
					cmd.push_start = 1'b1;
					state_d = ST_POP;
				end else begin
					cmd.clr_step = 1'b1;
				end
			end
			ST_POP: begin
				if (sts.stack_empty) begin
					state_d = ST_DONE;
				end else begin
					cmd.pop = 1'b1;
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (sts.no_edges) begin
					state_d = ST_POP;
				end else begin
					cmd.scan_rd = 1'b1;
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				state_d = ST_CHK;
			end
			ST_CHK: begin
				cmd.scan_eval = 1'b1;
				state_d = eval_last_q ? ST_POP : ST_SCAN;
			end
			ST_DONE: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			eval_last_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.scan_rd) eval_last_q <= sts.scan_last;
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

endmodule
